// ----- src/dsd_pkg.sv -----
// Shared definitions for the deck shuffle and draw unit: field widths,
// action codes, parameter defaults and the request/result structs.
// No dependencies.
package dsd_pkg;

	// Field widths fixed by the item format.
	localparam int CARD_W = 9;
	localparam int SIZE_W = 9;
	localparam int ACT_W  = 2;
	localparam int RAND_W = 15;

	// Parameter defaults.
	localparam int DECK_DEPTH_DEF = 256;
	localparam int RANDOM_MAX_DEF = 32767;

	// Reset value of the deck size register.
	localparam logic [SIZE_W-1:0] DECK_SIZE_RST = 9'd52;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_FILL    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SHUFFLE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DRAW    = 2'd2;

	// One accepted input item.
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [RAND_W-1:0] random_value;
	} dsd_req_t;

	// One result item.
	typedef struct packed {
		logic [CARD_W-1:0] card;
		logic              deck_empty;
		logic              shuffle_done;
		logic              step_ignored;
	} dsd_res_t;

endpackage

// ----- src/dsd_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by the shuffle engine for both divisions of a shuffle step.
// Depends on nothing outside this file.
module dsd_serial_div #(
	parameter int DVD_W = 15,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

	logic [DVD_W-1:0] shift_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, shift_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			dvs_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[DVD_W-2:0], fits};
			rem_q   <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = shift_q;

	// A started division is running in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");

endmodule

// ----- src/dsd_engine.sv -----
// Deck engine: card store, draw and shuffle positions and the sequencer
// that runs fill, shuffle step and draw. Uses dsd_pkg and dsd_serial_div.
module dsd_engine #(
	parameter int DECK_DEPTH = dsd_pkg::DECK_DEPTH_DEF,
	parameter int RANDOM_MAX = dsd_pkg::RANDOM_MAX_DEF,
	localparam int PW = $clog2(DECK_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dsd_pkg::dsd_req_t req,
	input  logic [PW-1:0]     n,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output dsd_pkg::dsd_res_t res
);
	import dsd_pkg::*;

	localparam int AW    = $clog2(DECK_DEPTH);
	localparam int RW    = $clog2(longint'(RANDOM_MAX) + 1);
	localparam int CW    = (RW > PW) ? RW : PW;
	localparam int DVS_W = (RW + 1 > PW) ? RW + 1 : PW;
	localparam int RVW   = (RW > RAND_W) ? RW : RAND_W;
	localparam logic [RW-1:0] RMAX_V = RW'(RANDOM_MAX);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_FILL      = 11'b000_0000_0010,
		ST_DIV1      = 11'b000_0000_0100,
		ST_DIV2      = 11'b000_0000_1000,
		ST_RD_I      = 11'b000_0001_0000,
		ST_RD_J      = 11'b000_0010_0000,
		ST_WR_I      = 11'b000_0100_0000,
		ST_WR_J      = 11'b000_1000_0000,
		ST_DRAW_RD   = 11'b001_0000_0000,
		ST_DRAW_TAKE = 11'b010_0000_0000,
		ST_RESULT    = 11'b100_0000_0000
	} eng_state_t;

	eng_state_t state_q;

	logic [PW-1:0]     draw_pos_q;
	logic [PW-1:0]     shuf_pos_q;
	logic              drawing_q;
	logic [PW-1:0]     k_q;
	logic [PW-1:0]     span_q;
	logic [PW-1:0]     j_q;
	logic [RW-1:0]     r_sat_q;
	logic [CARD_W-1:0] di_q;
	logic [CARD_W-1:0] card_q;
	logic              empty_q;
	logic              ignored_q;
	logic              div_start_q;
	logic [RW-1:0]     div_dvd_q;
	logic [DVS_W-1:0]  div_dvs_q;
	logic              div_done;
	logic [RW-1:0]     div_quot;

	logic [CARD_W-1:0] mem [DECK_DEPTH];
	logic [CARD_W-1:0] rd_data_q;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [CARD_W-1:0] wdata;

	logic              shuf_full;
	logic              draw_end;
	logic [PW-1:0]     span;
	logic [RVW-1:0]    r_ext;
	logic [RW-1:0]     r_sat;
	logic [CW-1:0]     quot_x;
	logic [CW-1:0]     span_x;

	// Status of the shuffle and draw positions against the deck size.
	assign shuf_full = (({1'b0, shuf_pos_q} + 1'b1) >= {1'b0, n});
	assign draw_end  = (draw_pos_q >= n);
	assign span      = n - shuf_pos_q;

	// Random word saturated to the largest legal value.
	assign r_ext = RVW'(req.random_value);
	assign r_sat = (r_ext > RVW'(RMAX_V)) ? RMAX_V : RW'(r_ext);

	// Offset from the second division, compared against the span.
	assign quot_x = CW'(div_quot);
	assign span_x = CW'(span_q);

	// Store port selection.
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = shuf_pos_q[AW-1:0];
		wdata   = rd_data_q;
		rd_addr = shuf_pos_q[AW-1:0];
		case (state_q)
			ST_FILL: begin
				mem_we  = 1'b1;
				wr_addr = k_q[AW-1:0];
				wdata   = CARD_W'(k_q + 1'b1);
			end
			ST_RD_J: begin
				rd_addr = j_q[AW-1:0];
			end
			ST_WR_I: begin
				mem_we = 1'b1;
			end
			ST_WR_J: begin
				mem_we  = 1'b1;
				wr_addr = j_q[AW-1:0];
				wdata   = di_q;
			end
			ST_DRAW_RD: begin
				rd_addr = draw_pos_q[AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Card store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	dsd_serial_div #(
		.DVD_W(RW),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			draw_pos_q  <= '0;
			shuf_pos_q  <= '0;
			drawing_q   <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (req.action)
							ACT_FILL: begin
								state_q <= ST_FILL;
							end
							ACT_SHUFFLE: begin
								if (drawing_q || shuf_full) begin
									state_q <= ST_RESULT;
								end else begin
									div_start_q <= 1'b1;
									state_q     <= ST_DIV1;
								end
							end
							ACT_DRAW: begin
								drawing_q <= 1'b1;
								state_q   <= draw_end ? ST_RESULT : ST_DRAW_RD;
							end
							default: begin
								state_q <= ST_RESULT;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (k_q == n - 1'b1) begin
						draw_pos_q <= '0;
						shuf_pos_q <= '0;
						drawing_q  <= 1'b0;
						state_q    <= ST_RESULT;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_RD_I;
					end
				end
				ST_RD_I: begin
					state_q <= ST_RD_J;
				end
				ST_RD_J: begin
					state_q <= ST_WR_I;
				end
				ST_WR_I: begin
					state_q <= ST_WR_J;
				end
				ST_WR_J: begin
					shuf_pos_q <= shuf_pos_q + 1'b1;
					state_q    <= ST_RESULT;
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_TAKE;
				end
				ST_DRAW_TAKE: begin
					draw_pos_q <= draw_pos_q + 1'b1;
					state_q    <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working values of the current item.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				k_q       <= '0;
				card_q    <= '0;
				empty_q   <= 1'b0;
				ignored_q <= 1'b0;
				span_q    <= span;
				r_sat_q   <= r_sat;
				div_dvd_q <= RMAX_V;
				div_dvs_q <= DVS_W'(span);
				if (start && req.action == ACT_SHUFFLE) begin
					ignored_q <= drawing_q | shuf_full;
				end
				if (start && req.action == ACT_DRAW) begin
					empty_q <= draw_end;
				end
			end
			ST_FILL: begin
				k_q <= k_q + 1'b1;
			end
			ST_DIV1: begin
				div_dvd_q <= r_sat_q;
				div_dvs_q <= DVS_W'({1'b0, div_quot} + 1'b1);
			end
			ST_DIV2: begin
				if (quot_x >= span_x) begin
					j_q <= n - 1'b1;
				end else begin
					j_q <= shuf_pos_q + PW'(quot_x);
				end
			end
			ST_RD_J: begin
				di_q <= rd_data_q;
			end
			ST_DRAW_TAKE: begin
				card_q <= rd_data_q;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign idle             = (state_q == ST_IDLE);
	assign res_valid        = (state_q == ST_RESULT);
	assign res.card         = card_q;
	assign res.deck_empty   = empty_q;
	assign res.shuffle_done = shuf_full;
	assign res.step_ignored = ignored_q;

	// The second write of a swap always follows the first.
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_J) |-> ($past(state_q) == ST_WR_I))
		else $error("swap write out of order");

	// An empty draw never reports a card.
	a_empty_card: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.deck_empty) |-> (res.card == '0))
		else $error("card reported on empty draw");

endmodule

// ----- src/deck_shuffle_and_draw_unit.sv -----
// A shuffle step runs the bit-serial divider twice; out_valid rises in the same cycle as the
// engine turns idle, so the next item can already be taken in that cycle.
// One item is worked at a time; the next is taken as soon as the engine is idle,
// even while the previous result waits in the output register.
// Reset clears positions and flags and loads deck size 52; the card store is undefined until a fill.
module deck_shuffle_and_draw_unit #(
	parameter int DECK_DEPTH = dsd_pkg::DECK_DEPTH_DEF,
	parameter int RANDOM_MAX = dsd_pkg::RANDOM_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dsd_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [dsd_pkg::ACT_W-1:0]  action,
	input  logic [dsd_pkg::RAND_W-1:0] random_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [dsd_pkg::CARD_W-1:0] card,
	output logic                        deck_empty,
	output logic                        shuffle_done,
	output logic                        step_ignored
);
	import dsd_pkg::*;

	localparam int PW  = $clog2(DECK_DEPTH + 1);
	localparam int CMW = (SIZE_W > PW) ? SIZE_W : PW;

	logic [SIZE_W-1:0] deck_size_q;
	logic [CMW-1:0]    size_x;
	logic [PW-1:0]     n_eff;
	logic              eng_idle;
	logic              start;
	dsd_req_t          req;
	logic              res_valid;
	logic              res_ready;
	dsd_res_t          res;
	logic              out_valid_q;
	dsd_res_t          out_res_q;

	// Deck size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_size_q <= DECK_SIZE_RST;
		end else if (cfg_we) begin
			deck_size_q <= cfg_wdata;
		end
	end

	// Effective deck size, clamped to one and to the store depth.
	assign size_x = CMW'(deck_size_q);
	always_comb begin
		if (size_x == '0) begin
			n_eff = PW'(1);
		end else if (size_x > CMW'(DECK_DEPTH)) begin
			n_eff = PW'(DECK_DEPTH);
		end else begin
			n_eff = PW'(size_x);
		end
	end

	// Input handshake: an item is taken whenever the engine is idle.
	assign in_stall         = !eng_idle;
	assign start            = in_valid && eng_idle;
	assign req.action       = action;
	assign req.random_value = random_value;

	dsd_engine #(
		.DECK_DEPTH(DECK_DEPTH),
		.RANDOM_MAX(RANDOM_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.n         (n_eff),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register, loaded when empty or being drained.
	assign res_ready = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign card         = out_res_q.card;
	assign deck_empty   = out_res_q.deck_empty;
	assign shuffle_done = out_res_q.shuffle_done;
	assign step_ignored = out_res_q.step_ignored;

	// Every accepted item makes the engine busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("engine idle right after accepting an item");

endmodule
